// ----- hdl/stl_pkg.sv -----
// Package for the solar-to-lunar date converter: ROM contents, field types,
// controller/datapath command and status structs. No dependencies.
package stl_pkg;

	localparam int TableYears = 199;
	localparam logic [11:0] FirstYear = 12'd1901;
	localparam logic [11:0] LastYear = 12'(1900 + TableYears);

	typedef logic [23:0] rom_word_t;

	typedef struct packed {
		logic load;     // latch input item, look up year word
		logic fetch;    // read previous year word for backward walk
		logic step;     // advance walk by one month
		logic finish;   // publish result
	} stl_cmd_t;

	typedef struct packed {
		logic reject;   // input out of range
		logic backward; // date before Spring Festival
		logic walk_done;
	} stl_sts_t;

	function automatic rom_word_t lunar_rom(input logic [7:0] idx);
		case (idx)
			8'd0: lunar_rom = 24'h04AE53; 8'd1: lunar_rom = 24'h0A5748; 8'd2: lunar_rom = 24'h5526BD;
			8'd3: lunar_rom = 24'h0D2650; 8'd4: lunar_rom = 24'h0D9544; 8'd5: lunar_rom = 24'h46AAB9;
			8'd6: lunar_rom = 24'h056A4D; 8'd7: lunar_rom = 24'h09AD42; 8'd8: lunar_rom = 24'h24AEB6;
			8'd9: lunar_rom = 24'h04AE4A; 8'd10: lunar_rom = 24'h6A4DBE; 8'd11: lunar_rom = 24'h0A4D52;
			8'd12: lunar_rom = 24'h0D2546; 8'd13: lunar_rom = 24'h5D52BA; 8'd14: lunar_rom = 24'h0B544E;
			8'd15: lunar_rom = 24'h0D6A43; 8'd16: lunar_rom = 24'h296D37; 8'd17: lunar_rom = 24'h095B4B;
			8'd18: lunar_rom = 24'h749BC1; 8'd19: lunar_rom = 24'h049754; 8'd20: lunar_rom = 24'h0A4B48;
			8'd21: lunar_rom = 24'h5B25BC; 8'd22: lunar_rom = 24'h06A550; 8'd23: lunar_rom = 24'h06D445;
			8'd24: lunar_rom = 24'h4ADAB8; 8'd25: lunar_rom = 24'h02B64D; 8'd26: lunar_rom = 24'h095742;
			8'd27: lunar_rom = 24'h2497B7; 8'd28: lunar_rom = 24'h04974A; 8'd29: lunar_rom = 24'h664B3E;
			8'd30: lunar_rom = 24'h0D4A51; 8'd31: lunar_rom = 24'h0EA546; 8'd32: lunar_rom = 24'h56D4BA;
			8'd33: lunar_rom = 24'h05AD4E; 8'd34: lunar_rom = 24'h02B644; 8'd35: lunar_rom = 24'h393738;
			8'd36: lunar_rom = 24'h092E4B; 8'd37: lunar_rom = 24'h7C96BF; 8'd38: lunar_rom = 24'h0C9553;
			8'd39: lunar_rom = 24'h0D4A48; 8'd40: lunar_rom = 24'h6DA53B; 8'd41: lunar_rom = 24'h0B554F;
			8'd42: lunar_rom = 24'h056A45; 8'd43: lunar_rom = 24'h4AADB9; 8'd44: lunar_rom = 24'h025D4D;
			8'd45: lunar_rom = 24'h092D42; 8'd46: lunar_rom = 24'h2C95B6; 8'd47: lunar_rom = 24'h0A954A;
			8'd48: lunar_rom = 24'h7B4ABD; 8'd49: lunar_rom = 24'h06CA51; 8'd50: lunar_rom = 24'h0B5546;
			8'd51: lunar_rom = 24'h555ABB; 8'd52: lunar_rom = 24'h04DA4E; 8'd53: lunar_rom = 24'h0A5B43;
			8'd54: lunar_rom = 24'h352BB8; 8'd55: lunar_rom = 24'h052B4C; 8'd56: lunar_rom = 24'h8A953F;
			8'd57: lunar_rom = 24'h0E9552; 8'd58: lunar_rom = 24'h06AA48; 8'd59: lunar_rom = 24'h6AD53C;
			8'd60: lunar_rom = 24'h0AB54F; 8'd61: lunar_rom = 24'h04B645; 8'd62: lunar_rom = 24'h4A5739;
			8'd63: lunar_rom = 24'h0A574D; 8'd64: lunar_rom = 24'h052642; 8'd65: lunar_rom = 24'h3E9335;
			8'd66: lunar_rom = 24'h0D9549; 8'd67: lunar_rom = 24'h75AABE; 8'd68: lunar_rom = 24'h056A51;
			8'd69: lunar_rom = 24'h096D46; 8'd70: lunar_rom = 24'h54AEBB; 8'd71: lunar_rom = 24'h04AD4F;
			8'd72: lunar_rom = 24'h0A4D43; 8'd73: lunar_rom = 24'h4D26B7; 8'd74: lunar_rom = 24'h0D254B;
			8'd75: lunar_rom = 24'h8D52BF; 8'd76: lunar_rom = 24'h0B5452; 8'd77: lunar_rom = 24'h0B6A47;
			8'd78: lunar_rom = 24'h696D3C; 8'd79: lunar_rom = 24'h095B50; 8'd80: lunar_rom = 24'h049B45;
			8'd81: lunar_rom = 24'h4A4BB9; 8'd82: lunar_rom = 24'h0A4B4D; 8'd83: lunar_rom = 24'hAB25C2;
			8'd84: lunar_rom = 24'h06A554; 8'd85: lunar_rom = 24'h06D449; 8'd86: lunar_rom = 24'h6ADA3D;
			8'd87: lunar_rom = 24'h0AB651; 8'd88: lunar_rom = 24'h093746; 8'd89: lunar_rom = 24'h5497BB;
			8'd90: lunar_rom = 24'h04974F; 8'd91: lunar_rom = 24'h064B44; 8'd92: lunar_rom = 24'h36A537;
			8'd93: lunar_rom = 24'h0EA54A; 8'd94: lunar_rom = 24'h86B2BF; 8'd95: lunar_rom = 24'h05AC53;
			8'd96: lunar_rom = 24'h0AB647; 8'd97: lunar_rom = 24'h5936BC; 8'd98: lunar_rom = 24'h092E50;
			8'd99: lunar_rom = 24'h0C9645; 8'd100: lunar_rom = 24'h4D4AB8; 8'd101: lunar_rom = 24'h0D4A4C;
			8'd102: lunar_rom = 24'h0DA541; 8'd103: lunar_rom = 24'h25AAB6; 8'd104: lunar_rom = 24'h056A49;
			8'd105: lunar_rom = 24'h7AADBD; 8'd106: lunar_rom = 24'h025D52; 8'd107: lunar_rom = 24'h092D47;
			8'd108: lunar_rom = 24'h5C95BA; 8'd109: lunar_rom = 24'h0A954E; 8'd110: lunar_rom = 24'h0B4A43;
			8'd111: lunar_rom = 24'h4B5537; 8'd112: lunar_rom = 24'h0AD54A; 8'd113: lunar_rom = 24'h955ABF;
			8'd114: lunar_rom = 24'h04BA53; 8'd115: lunar_rom = 24'h0A5B48; 8'd116: lunar_rom = 24'h652BBC;
			8'd117: lunar_rom = 24'h052B50; 8'd118: lunar_rom = 24'h0A9345; 8'd119: lunar_rom = 24'h474AB9;
			8'd120: lunar_rom = 24'h06AA4C; 8'd121: lunar_rom = 24'h0AD541; 8'd122: lunar_rom = 24'h24DAB6;
			8'd123: lunar_rom = 24'h04B64A; 8'd124: lunar_rom = 24'h69573D; 8'd125: lunar_rom = 24'h0A4E51;
			8'd126: lunar_rom = 24'h0D2646; 8'd127: lunar_rom = 24'h5E933A; 8'd128: lunar_rom = 24'h0D534D;
			8'd129: lunar_rom = 24'h05AA43; 8'd130: lunar_rom = 24'h36B537; 8'd131: lunar_rom = 24'h096D4B;
			8'd132: lunar_rom = 24'hB4AEBF; 8'd133: lunar_rom = 24'h04AD53; 8'd134: lunar_rom = 24'h0A4D48;
			8'd135: lunar_rom = 24'h6D25BC; 8'd136: lunar_rom = 24'h0D254F; 8'd137: lunar_rom = 24'h0D5244;
			8'd138: lunar_rom = 24'h5DAA38; 8'd139: lunar_rom = 24'h0B5A4C; 8'd140: lunar_rom = 24'h056D41;
			8'd141: lunar_rom = 24'h24ADB6; 8'd142: lunar_rom = 24'h049B4A; 8'd143: lunar_rom = 24'h7A4BBE;
			8'd144: lunar_rom = 24'h0A4B51; 8'd145: lunar_rom = 24'h0AA546; 8'd146: lunar_rom = 24'h5B52BA;
			8'd147: lunar_rom = 24'h06D24E; 8'd148: lunar_rom = 24'h0ADA42; 8'd149: lunar_rom = 24'h355B37;
			8'd150: lunar_rom = 24'h09374B; 8'd151: lunar_rom = 24'h8497C1; 8'd152: lunar_rom = 24'h049753;
			8'd153: lunar_rom = 24'h064B48; 8'd154: lunar_rom = 24'h66A53C; 8'd155: lunar_rom = 24'h0EA54F;
			8'd156: lunar_rom = 24'h06B244; 8'd157: lunar_rom = 24'h4AB638; 8'd158: lunar_rom = 24'h0AAE4C;
			8'd159: lunar_rom = 24'h092E42; 8'd160: lunar_rom = 24'h3C9735; 8'd161: lunar_rom = 24'h0C9649;
			8'd162: lunar_rom = 24'h7D4ABD; 8'd163: lunar_rom = 24'h0D4A51; 8'd164: lunar_rom = 24'h0DA545;
			8'd165: lunar_rom = 24'h55AABA; 8'd166: lunar_rom = 24'h056A4E; 8'd167: lunar_rom = 24'h0A6D43;
			8'd168: lunar_rom = 24'h452EB7; 8'd169: lunar_rom = 24'h052D4B; 8'd170: lunar_rom = 24'h8A95BF;
			8'd171: lunar_rom = 24'h0A9553; 8'd172: lunar_rom = 24'h0B4A47; 8'd173: lunar_rom = 24'h6B553B;
			8'd174: lunar_rom = 24'h0AD54F; 8'd175: lunar_rom = 24'h055A45; 8'd176: lunar_rom = 24'h4A5D38;
			8'd177: lunar_rom = 24'h0A5B4C; 8'd178: lunar_rom = 24'h052B42; 8'd179: lunar_rom = 24'h3A93B6;
			8'd180: lunar_rom = 24'h069349; 8'd181: lunar_rom = 24'h7729BD; 8'd182: lunar_rom = 24'h06AA51;
			8'd183: lunar_rom = 24'h0AD546; 8'd184: lunar_rom = 24'h54DABA; 8'd185: lunar_rom = 24'h04B64E;
			8'd186: lunar_rom = 24'h0A5743; 8'd187: lunar_rom = 24'h452738; 8'd188: lunar_rom = 24'h0D264A;
			8'd189: lunar_rom = 24'h8E933E; 8'd190: lunar_rom = 24'h0D5252; 8'd191: lunar_rom = 24'h0DAA47;
			8'd192: lunar_rom = 24'h66B53B; 8'd193: lunar_rom = 24'h056D4F; 8'd194: lunar_rom = 24'h04AE45;
			8'd195: lunar_rom = 24'h4A4EB9; 8'd196: lunar_rom = 24'h0A4D4C; 8'd197: lunar_rom = 24'h0D1541;
			8'd198: lunar_rom = 24'h2D92B5;
			default: lunar_rom = 24'h000000;
		endcase
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] mon);
		case (mon)
			4'd1: days_before = 9'd0;    4'd2: days_before = 9'd31;
			4'd3: days_before = 9'd59;   4'd4: days_before = 9'd90;
			4'd5: days_before = 9'd120;  4'd6: days_before = 9'd151;
			4'd7: days_before = 9'd181;  4'd8: days_before = 9'd212;
			4'd9: days_before = 9'd243;  4'd10: days_before = 9'd273;
			4'd11: days_before = 9'd304; 4'd12: days_before = 9'd334;
			default: days_before = 9'd0;
		endcase
	endfunction

endpackage

// ----- hdl/stl_datapath.sv -----
// Datapath of the date converter: input latch, ROM lookup, day-of-year,
// month walk counters and result register. Depends on stl_pkg.
module stl_datapath (
	input  logic              clk,
	input  logic [11:0]       in_year,
	input  logic [3:0]        in_month,
	input  logic [4:0]        in_day,
	input  stl_pkg::stl_cmd_t cmd,
	output stl_pkg::stl_sts_t sts,
	output logic [11:0]       res_year,
	output logic [3:0]        res_month,
	output logic [4:0]        res_day,
	output logic              res_oor
);
	import stl_pkg::*;

	logic [11:0] year_q;
	logic [3:0]  mon_q;
	logic [4:0]  day_q;
	rom_word_t   word_q;
	logic        back_q;
	logic        rej_q;
	logic [8:0]  cnt_q;   // forward offset or backward remainder
	logic [3:0]  idx_q;

	// combinational prep of the latched date
	logic [7:0]  yoff;
	logic [8:0]  sf, doy;
	logic        bad;
	assign yoff = 8'(year_q - FirstYear);
	assign bad  = (year_q < FirstYear) || (year_q > LastYear) || (mon_q == 4'd0)
		|| (mon_q > 4'd12) || (day_q == 5'd0);
	always_comb begin
		sf = 9'({4'd0, word_q[4:0]} - 9'd1);
		if (word_q[6:5] != 2'd1) sf = sf + 9'd31;
		if (word_q[4:0] == 5'd0) sf = 9'd0;
		doy = days_before(mon_q) + 9'(day_q) - 9'd1;
		if (year_q[1:0] == 2'b00 && mon_q > 4'd2) doy = doy + 9'd1;
	end

	logic [3:0] leap;
	logic [4:0] days;
	logic       flag;
	assign leap = word_q[23:20];
	assign flag = word_q[5'd20 - 5'(idx_q)];
	assign days = flag ? 5'd30 : 5'd29;

	logic [3:0] label;
	assign label = (leap == 4'd0 || idx_q <= leap) ? idx_q : idx_q - 4'd1;

	logic fwd_done, bwd_done;
	assign fwd_done = (cnt_q < 9'(days)) || (idx_q >= 4'd13);
	assign bwd_done = (cnt_q <= 9'(days)) || (idx_q <= 4'd1);

	logic [1:0] phase_q; // 0 latch, 1 word valid: classify, 2 walking
	logic [8:0] rem_clip;
	assign rem_clip = (cnt_q > 9'(days)) ? 9'(days) : cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q  <= in_year;
			mon_q   <= in_month;
			day_q   <= in_day;
			phase_q <= 2'd0;
		end else if (phase_q == 2'd0) begin
			word_q  <= lunar_rom(yoff);
			rej_q   <= bad;
			phase_q <= 2'd1;
		end else if (phase_q == 2'd1) begin
			back_q  <= (doy < sf);
			if (doy >= sf) begin
				cnt_q <= doy - sf;
				idx_q <= 4'd1;
			end else begin
				cnt_q <= sf - doy;
				if (year_q == FirstYear) rej_q <= 1'b1;
			end
			phase_q <= 2'd2;
		end else if (cmd.fetch) begin
			word_q <= lunar_rom(8'(yoff - 8'd1));
			idx_q  <= (lunar_rom(8'(yoff - 8'd1)) == 24'd0) ? 4'd12 :
				((lunar_rom(8'(yoff - 8'd1)) >> 20) == 24'd0 ? 4'd12 : 4'd13);
			year_q <= year_q - 12'd1;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 9'(days);
			idx_q <= back_q ? idx_q - 4'd1 : idx_q + 4'd1;
		end
		if (cmd.finish) begin
			res_oor   <= rej_q;
			res_year  <= rej_q ? 12'd0 : year_q;
			res_month <= rej_q ? 4'd0 : label;
			res_day   <= rej_q ? 5'd0 :
				(back_q ? 5'(9'(days) - rem_clip + 9'd1) : 5'(cnt_q + 9'd1));
		end
	end

	assign sts.reject    = rej_q;
	assign sts.backward  = back_q;
	assign sts.walk_done = back_q ? bwd_done : fwd_done;

endmodule

// ----- hdl/stl_ctrl.sv -----
// Controller of the date converter: sequences lookup, walk and output
// handshake. Depends on stl_pkg.
module stl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output stl_pkg::stl_cmd_t cmd,
	input  stl_pkg::stl_sts_t sts
);
	import stl_pkg::*;

	localparam logic [2:0] SIdle = 3'd0, SLook = 3'd1, SClass = 3'd2, SDecide = 3'd3,
		SFetch = 3'd4, SWalk = 3'd5, SOut = 3'd6;

	logic [2:0] state_q;
	logic       ovalid_q;

	assign in_ready  = (state_q == SIdle) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = in_valid && in_ready;
		cmd.fetch  = (state_q == SFetch);
		cmd.step   = (state_q == SWalk) && !sts.walk_done;
		cmd.finish = (state_q == SOut) || (state_q == SDecide && sts.reject);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SIdle;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				SIdle:   if (cmd.load) state_q <= SLook;
				SLook:   state_q <= SClass;
				SClass:  state_q <= SDecide;
				SDecide: begin
					if (sts.reject) begin
						ovalid_q <= 1'b1;
						state_q  <= SIdle;
					end else if (sts.backward) state_q <= SFetch;
					else state_q <= SWalk;
				end
				SFetch:  state_q <= SWalk;
				SWalk:   if (sts.walk_done) state_q <= SOut;
				SOut: begin
					ovalid_q <= 1'b1;
					state_q  <= SIdle;
				end
				default: state_q <= SIdle;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == SIdle) else $error("accept while busy");
	a_step_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> state_q == SWalk) else $error("step outside walk");
	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> ovalid_q) else $error("result lost");
endmodule

// ----- hdl/solar_to_lunar_date.sv -----
// Top level of the Gregorian to Chinese lunar date converter (1901-2099).
// Depends on stl_pkg, stl_ctrl, stl_datapath.
//
//  channel  | dir | tdata fields (low bit up)                 | tuser
//  s_axis   | in  | solar_year[11:0] month[15:12] day[20:16]   | -
//  m_axis   | out | lunar_year[11:0] month[15:12] day[20:16]   | out_of_range
//
// One item at a time. From the accepted beat: lookup and classification (SLook, SClass,
// SDecide), then the month walk, one lunar month per cycle (1 to 13 months visited),
// then the result register (SOut), with a previous-year ROM read (SFetch) before the
// walk on dates before the Spring Festival. A rejected date is published from SDecide
// with no walk. After each result the controller returns to SIdle before it can take
// the next beat.
// Reset (arst_n low) clears the controller and the output valid flag.
// A waiting result is held; the next beat is taken once the result leaves
// or in the same cycle it is taken.
module solar_to_lunar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // solar_year, solar_month, solar_day
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // lunar_year, lunar_month, lunar_day
	output logic        m_axis_tuser    // out_of_range
);
	import stl_pkg::*;

	stl_cmd_t    cmd;
	stl_sts_t    sts;
	logic [11:0] ry;
	logic [3:0]  rm;
	logic [4:0]  rd;

	stl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	stl_datapath u_dp (
		.clk(clk),
		.in_year(s_axis_tdata[11:0]), .in_month(s_axis_tdata[15:12]),
		.in_day(s_axis_tdata[20:16]),
		.cmd(cmd), .sts(sts),
		.res_year(ry), .res_month(rm), .res_day(rd), .res_oor(m_axis_tuser)
	);

	assign m_axis_tdata = {3'd0, rd, rm, ry};
endmodule
